### rtl/core/pf_pkg.sv
// ---------------------------------------------------------------------------
// pf_pkg
// Shared types, constants and helpers of the Playfair encryptor.
// ---------------------------------------------------------------------------
`default_nettype none

package pf_pkg;

  localparam int unsigned GRID_SIDE   = 5;
  localparam int unsigned GRID_CELLS  = GRID_SIDE * GRID_SIDE;
  localparam int unsigned ALPHA_COUNT = 26;

  localparam int unsigned LW = 5;  // letter index width
  localparam int unsigned RW = 3;  // row / column width
  localparam int unsigned AW = 5;  // grid address width

  localparam logic [LW-1:0] LET_I     = LW'(8);
  localparam logic [LW-1:0] LET_J     = LW'(9);
  localparam logic [LW-1:0] LET_X     = LW'(23);
  localparam logic [LW-1:0] LET_LAST  = LW'(ALPHA_COUNT - 1);
  localparam logic [6:0]    ASCII_A   = 7'd65;
  localparam logic [AW-1:0] CELLS_END = AW'(GRID_CELLS);

  typedef enum logic [1:0] {
    MODE_KEY      = 2'd0,
    MODE_KEY_END  = 2'd1,
    MODE_TEXT     = 2'd2,
    MODE_TEXT_END = 2'd3
  } pf_mode_e;

  typedef enum logic [1:0] {
    OP_PLACE = 2'd0,
    OP_FILL  = 2'd1,
    OP_ENC   = 2'd2
  } pf_op_e;

  typedef struct packed {
    pf_op_e        op;
    logic [LW-1:0] let_a;
    logic [LW-1:0] let_b;
  } pf_cmd_t;

  typedef struct packed {
    logic          valid;
    logic [LW-1:0] idx;
  } pf_letter_t;

  typedef struct packed {
    logic [RW-1:0] row;
    logic [RW-1:0] col;
  } pf_pos_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_FILL,
    B_LOOK,
    B_GRID,
    B_OUT0,
    B_OUT1
  } pf_back_state_e;

  // ASCII byte to letter index, J folded to I
  function automatic pf_letter_t letter_of(input logic [7:0] b);
    pf_letter_t r;
    r.valid = 1'b0;
    r.idx   = '0;
    if (b >= 8'd65 && b <= 8'd90) begin
      r.valid = 1'b1;
      r.idx   = LW'(b - 8'd65);
    end else if (b >= 8'd97 && b <= 8'd122) begin
      r.valid = 1'b1;
      r.idx   = LW'(b - 8'd97);
    end
    if (r.idx == LET_J) begin
      r.idx = LET_I;
    end
    return r;
  endfunction

  function automatic logic [RW-1:0] wrap_inc(input logic [RW-1:0] v);
    return (v == RW'(GRID_SIDE - 1)) ? '0 : v + RW'(1);
  endfunction

  function automatic logic [AW-1:0] cell_addr(input logic [RW-1:0] r,
                                              input logic [RW-1:0] c);
    return AW'(r) * AW'(GRID_SIDE) + AW'(c);
  endfunction

endpackage

`default_nettype wire

### rtl/core/pf_if.sv
// ---------------------------------------------------------------------------
// pf_if
// Valid/ready channels of the Playfair encryptor: input items and cipher letters.
// ---------------------------------------------------------------------------
`default_nettype none

interface pf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] char_in;

  modport source (output valid, output mode, output char_in, input ready);
  modport sink   (input valid, input mode, input char_in, output ready);
endinterface

interface pf_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] cipher_char;
  logic       pair_last;

  modport source (output valid, output cipher_char, output pair_last, input ready);
  modport sink   (input valid, input cipher_char, input pair_last, output ready);
endinterface

`default_nettype wire

### rtl/core/pf_fifo.sv
// ---------------------------------------------------------------------------
// pf_fifo
// Small command queue between the front end and the execution sequencer.
// ---------------------------------------------------------------------------
`default_nettype none

module pf_fifo #(
  parameter int unsigned DEPTH = 4
) (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   push_i,
  input  wire pf_pkg::pf_cmd_t  push_data_i,
  output logic                  full_o,
  input  wire                   pop_i,
  output pf_pkg::pf_cmd_t       pop_data_o,
  output logic                  empty_o
);
  import pf_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  pf_cmd_t         mem_q [DEPTH];
  logic [PW-1:0]   wr_q, wr_d, rd_q, rd_d;
  logic [CW-1:0]   cnt_q, cnt_d;
  logic            push_ok, pop_ok;

  assign full_o     = (cnt_q == CW'(DEPTH));
  assign empty_o    = (cnt_q == '0);
  assign push_ok    = push_i && !full_o;
  assign pop_ok     = pop_i && !empty_o;
  assign pop_data_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_ok) begin
      wr_d = (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
    end
    if (pop_ok) begin
      rd_d = (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
    end
    if (push_ok && !pop_ok) begin
      cnt_d = cnt_q + CW'(1);
    end else if (pop_ok && !push_ok) begin
      cnt_d = cnt_q - CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

### rtl/core/pf_front.sv
// ---------------------------------------------------------------------------
// pf_front
// Accepts input items, decodes letters, pairs text letters and queues commands.
// ---------------------------------------------------------------------------
`default_nettype none

module pf_front (
  input  wire              clk_i,
  input  wire              rst_ni,
  pf_in_if.sink            in_i,
  output logic             push_o,
  output pf_pkg::pf_cmd_t  cmd_o,
  input  wire              full_i
);
  import pf_pkg::*;

  logic          held_valid_q, held_valid_d;
  logic [LW-1:0] held_letter_q, held_letter_d;
  logic          take;
  pf_letter_t    ltr;

  assign in_i.ready = !full_i;
  assign take       = in_i.valid && !full_i;
  assign ltr        = letter_of(in_i.char_in);

  always_comb begin
    push_o        = 1'b0;
    cmd_o.op      = OP_PLACE;
    cmd_o.let_a   = ltr.idx;
    cmd_o.let_b   = ltr.idx;
    held_valid_d  = held_valid_q;
    held_letter_d = held_letter_q;
    case (pf_mode_e'(in_i.mode))
      MODE_KEY: begin
        push_o = take && ltr.valid;
      end
      MODE_KEY_END: begin
        cmd_o.op = OP_FILL;
        push_o   = take;
      end
      MODE_TEXT: begin
        cmd_o.op    = OP_ENC;
        cmd_o.let_a = held_letter_q;
        if (take && ltr.valid) begin
          if (held_valid_q) begin
            push_o       = 1'b1;
            held_valid_d = 1'b0;
          end else begin
            held_valid_d  = 1'b1;
            held_letter_d = ltr.idx;
          end
        end
      end
      MODE_TEXT_END: begin
        // odd letter left over: pad with X
        cmd_o.op    = OP_ENC;
        cmd_o.let_a = held_letter_q;
        cmd_o.let_b = LET_X;
        if (take && held_valid_q) begin
          push_o       = 1'b1;
          held_valid_d = 1'b0;
        end
      end
      default: begin
        push_o = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_valid_q  <= 1'b0;
      held_letter_q <= '0;
    end else begin
      held_valid_q  <= held_valid_d;
      held_letter_q <= held_letter_d;
    end
  end

endmodule

`default_nettype wire

### rtl/core/pf_back.sv
// ---------------------------------------------------------------------------
// pf_back
// Executes queued commands: builds the key grid and encrypts letter pairs.
// ---------------------------------------------------------------------------
`default_nettype none

module pf_back (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire pf_pkg::pf_cmd_t  cmd_i,
  input  wire                   empty_i,
  output logic                  pop_o,
  pf_out_if.source              out_o
);
  import pf_pkg::*;

  pf_back_state_e state_q, state_d;

  logic [ALPHA_COUNT-1:0] used_q, used_d;
  logic [AW-1:0]          fill_count_q, fill_count_d;
  logic [RW-1:0]          fill_row_q, fill_row_d, fill_col_q, fill_col_d;
  logic [LW-1:0]          walk_q, walk_d;

  logic [LW-1:0] grid_mem [GRID_CELLS];
  pf_pos_t       pos_mem  [ALPHA_COUNT];

  pf_pos_t       pos_a_q, pos_b_q;
  logic [LW-1:0] grid_x_q, grid_y_q;
  logic [LW-1:0] out_x_q, out_y_q;

  logic          place_en;
  logic [LW-1:0] place_idx;
  logic          do_place;
  logic [RW-1:0] xr, xc, yr, yc;
  logic [AW-1:0] addr_x, addr_y;

  // placement is shared by key letters and the key-end walk
  assign do_place = place_en && (fill_count_q != CELLS_END) && !used_q[place_idx];

  always_comb begin
    if (pos_a_q.row == pos_b_q.row) begin
      xr = pos_a_q.row;
      xc = wrap_inc(pos_a_q.col);
      yr = pos_b_q.row;
      yc = wrap_inc(pos_b_q.col);
    end else if (pos_a_q.col == pos_b_q.col) begin
      xr = wrap_inc(pos_a_q.row);
      xc = pos_a_q.col;
      yr = wrap_inc(pos_b_q.row);
      yc = pos_b_q.col;
    end else begin
      xr = pos_a_q.row;
      xc = pos_b_q.col;
      yr = pos_b_q.row;
      yc = pos_a_q.col;
    end
    addr_x = cell_addr(xr, xc);
    addr_y = cell_addr(yr, yc);
  end

  always_comb begin
    state_d      = state_q;
    pop_o        = 1'b0;
    place_en     = 1'b0;
    place_idx    = cmd_i.let_a;
    walk_d       = walk_q;
    used_d       = used_q;
    fill_count_d = fill_count_q;
    fill_row_d   = fill_row_q;
    fill_col_d   = fill_col_q;
    out_o.valid  = 1'b0;
    case (state_q)
      B_IDLE: begin
        if (!empty_i) begin
          pop_o = 1'b1;
          case (cmd_i.op)
            OP_PLACE: place_en = 1'b1;
            OP_FILL: begin
              walk_d  = '0;
              state_d = B_FILL;
            end
            OP_ENC:  state_d = B_LOOK;
            default: state_d = B_IDLE;
          endcase
        end
      end
      B_FILL: begin
        place_idx = walk_q;
        place_en  = (walk_q != LET_J);
        walk_d    = walk_q + LW'(1);
        if (walk_q == LET_LAST) begin
          state_d = B_IDLE;
        end
      end
      B_LOOK: state_d = B_GRID;
      B_GRID: state_d = B_OUT0;
      B_OUT0: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          state_d = B_OUT1;
        end
      end
      B_OUT1: begin
        out_o.valid = 1'b1;
        if (out_o.ready) begin
          state_d = B_IDLE;
        end
      end
      default: state_d = B_IDLE;
    endcase
    if (do_place) begin
      used_d[place_idx] = 1'b1;
      fill_count_d      = fill_count_q + AW'(1);
      if (fill_col_q == RW'(GRID_SIDE - 1)) begin
        fill_col_d = '0;
        fill_row_d = fill_row_q + RW'(1);
      end else begin
        fill_col_d = fill_col_q + RW'(1);
      end
    end
  end

  assign out_o.cipher_char = ASCII_A + 7'((state_q == B_OUT1) ? out_y_q : out_x_q);
  assign out_o.pair_last   = (state_q == B_OUT1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= B_IDLE;
      used_q       <= '0;
      fill_count_q <= '0;
      fill_row_q   <= '0;
      fill_col_q   <= '0;
      walk_q       <= '0;
    end else begin
      state_q      <= state_d;
      used_q       <= used_d;
      fill_count_q <= fill_count_d;
      fill_row_q   <= fill_row_d;
      fill_col_q   <= fill_col_d;
      walk_q       <= walk_d;
    end
  end

  // grid and letter position stores, registered reads
  always_ff @(posedge clk_i) begin
    if (do_place) begin
      grid_mem[fill_count_q] <= place_idx;
      pos_mem[place_idx]     <= '{row: fill_row_q, col: fill_col_q};
    end
    pos_a_q  <= pos_mem[cmd_i.let_a];
    pos_b_q  <= pos_mem[cmd_i.let_b];
    grid_x_q <= grid_mem[addr_x];
    grid_y_q <= grid_mem[addr_y];
    if (state_q == B_GRID) begin
      out_x_q <= grid_x_q;
      out_y_q <= grid_y_q;
    end
  end

endmodule

`default_nettype wire

### rtl/core/playfair_encryptor.sv
// ---------------------------------------------------------------------------
// playfair_encryptor
// Playfair encryptor on a byte stream with a key grid built from key bytes.
// ---------------------------------------------------------------------------
// The input channel takes one item per cycle while the command queue has room.
// Text letters that open a pair and non-letter bytes only update the front end
// and never occupy the queue. The execution sequencer places a key letter at
// dispatch, walks over all 26 letters after a key end, and takes a letter pair
// through dispatch, position lookup, grid lookup and then one cipher letter
// after the other, holding each while the output is stalled. Keys must be
// complete (key end seen) before text is sent; a new key needs a reset.
`default_nettype none

module playfair_encryptor #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire       clk_i,
  input  wire       rst_ni,
  pf_in_if.sink     in_i,
  pf_out_if.source  out_o
);
  import pf_pkg::*;

  pf_cmd_t push_cmd, head_cmd;
  logic    push, full, pop, empty;

  pf_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_i),
    .push_o (push),
    .cmd_o  (push_cmd),
    .full_i (full)
  );

  pf_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .empty_o     (empty)
  );

  pf_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (head_cmd),
    .empty_i (empty),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

`default_nettype wire
